### hw/rtl/tca_pkg.sv
// Package for the traffic cellular automaton step unit.
// Holds payload and control structs, register and action codes, defaults and the LFSR step.
// Used by every RTL file of the block; depends on nothing.
package tca_pkg;

  localparam int ROAD_CELLS_DEF = 256;
  localparam int LANES_DEF      = 4;
  localparam int SPEED_BITS_DEF = 4;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_STEP  = 2'd2;

  localparam int          CFG_AW   = 3;
  localparam int          CFG_DW   = 16;
  localparam logic [2:0]  CFG_VMAX  = 3'd0;
  localparam logic [2:0]  CFG_PROB  = 3'd1;
  localparam logic [2:0]  CFG_LEN   = 3'd2;
  localparam logic [2:0]  CFG_LANES = 3'd3;
  localparam logic [2:0]  CFG_SEED  = 3'd4;

  localparam logic [3:0]  VMAX_RST  = 4'd5;
  localparam logic [15:0] PROB_RST  = 16'd19661;
  localparam logic [8:0]  LEN_RST   = 9'd256;
  localparam logic [2:0]  LANES_RST = 3'd1;
  localparam logic [15:0] SEED_RST  = 16'd44257;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] lane;
    logic [7:0] cell_req;
    logic       occupied_in;
    logic [3:0] velocity_in;
  } in_item_t;

  typedef struct packed {
    logic       occupied_out;
    logic [3:0] velocity_out;
    logic       step_done;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_wr;
    logic take_item;
    logic cell_wr;
    logic cell_rd;
    logic lane_init;
    logic lane_next;
    logic vel_init;
    logic vel_rd;
    logic vel_eval;
    logic vel_final;
    logic mv_init;
    logic mv_rd;
    logic mv_clr;
    logic mv_put;
    logic mv_dec;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       clr_last;
    logic [1:0] act;
    logic       lane_more;
    logic       p_last;
    logic       car;
    logic       any_car;
    logic       mv_last;
  } status_t;

  function automatic logic [15:0] lfsr_step(input logic [15:0] x);
    lfsr_step = (x >> 1) ^ (x[0] ? LFSR_TAPS : 16'h0000);
  endfunction

endpackage

### hw/rtl/tca_ctrl.sv
// Controller state machine of the traffic automaton step unit.
// Sequences clearing, cell access and the velocity and move sweeps; depends on tca_pkg.
module tca_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  tca_pkg::status_t st,
  output tca_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_EXEC   = 4'd2;
  localparam logic [3:0] S_RDWAIT = 4'd3;
  localparam logic [3:0] S_LANE   = 4'd4;
  localparam logic [3:0] S_VRD    = 4'd5;
  localparam logic [3:0] S_VEV    = 4'd6;
  localparam logic [3:0] S_VFIN   = 4'd7;
  localparam logic [3:0] S_MRD    = 4'd8;
  localparam logic [3:0] S_MEV    = 4'd9;
  localparam logic [3:0] S_MCLR   = 4'd10;
  localparam logic [3:0] S_MPUT   = 4'd11;
  localparam logic [3:0] S_RESULT = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (st.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_item = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        case (st.act)
          tca_pkg::ACT_WRITE: begin
            cmd.cell_wr = 1'b1;
            state_nxt   = S_RESULT;
          end
          tca_pkg::ACT_READ: begin
            cmd.cell_rd = 1'b1;
            state_nxt   = S_RDWAIT;
          end
          tca_pkg::ACT_STEP: begin
            cmd.lane_init = 1'b1;
            state_nxt     = S_LANE;
          end
          default: state_nxt = S_RESULT;
        endcase
      end
      S_RDWAIT: state_nxt = S_RESULT;
      S_LANE: begin
        if (st.lane_more) begin
          cmd.vel_init = 1'b1;
          state_nxt    = S_VRD;
        end else begin
          state_nxt = S_RESULT;
        end
      end
      S_VRD: begin
        cmd.vel_rd = 1'b1;
        state_nxt  = S_VEV;
      end
      S_VEV: begin
        cmd.vel_eval = 1'b1;
        state_nxt    = st.p_last ? S_VFIN : S_VRD;
      end
      S_VFIN: begin
        cmd.vel_final = 1'b1;
        if (st.any_car) begin
          cmd.mv_init = 1'b1;
          state_nxt   = S_MRD;
        end else begin
          cmd.lane_next = 1'b1;
          state_nxt     = S_LANE;
        end
      end
      S_MRD: begin
        cmd.mv_rd = 1'b1;
        state_nxt = S_MEV;
      end
      S_MEV: begin
        if (st.car) begin
          state_nxt = S_MCLR;
        end else if (st.mv_last) begin
          cmd.lane_next = 1'b1;
          state_nxt     = S_LANE;
        end else begin
          cmd.mv_dec = 1'b1;
          state_nxt  = S_MRD;
        end
      end
      S_MCLR: begin
        cmd.mv_clr = 1'b1;
        state_nxt  = S_MPUT;
      end
      S_MPUT: begin
        cmd.mv_put = 1'b1;
        if (st.mv_last) begin
          cmd.lane_next = 1'b1;
          state_nxt     = S_LANE;
        end else begin
          cmd.mv_dec = 1'b1;
          state_nxt  = S_MRD;
        end
      end
      S_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hw/rtl/tca_datapath.sv
// Datapath of the traffic automaton step unit: cell memory, sweep counters, LFSR,
// configuration registers and the result register. Depends on tca_pkg.
module tca_datapath #(
  parameter int ROAD_CELLS = tca_pkg::ROAD_CELLS_DEF,
  parameter int LANES      = tca_pkg::LANES_DEF,
  parameter int SPEED_BITS = tca_pkg::SPEED_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tca_pkg::in_item_t          in_data,
  input  logic                       cfg_we,
  input  logic [tca_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [tca_pkg::CFG_DW-1:0] cfg_wdata,
  input  tca_pkg::cmd_t              cmd,
  output tca_pkg::status_t           st,
  output tca_pkg::out_item_t         out_data
);

  localparam int DEPTH = LANES * ROAD_CELLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(ROAD_CELLS);
  localparam int LW    = $clog2(ROAD_CELLS + 1);
  localparam int LCW   = $clog2(LANES + 1);
  localparam int SB    = SPEED_BITS;
  localparam int VMASK = (1 << SPEED_BITS) - 1;

  logic [SB:0] mem [DEPTH];

  logic [3:0]  vmax_cfg_r;
  logic [15:0] prob_r;
  logic [8:0]  len_cfg_r;
  logic [2:0]  lanes_cfg_r;
  logic [15:0] lfsr_r, lfsr_nxt;

  tca_pkg::in_item_t  item_r;
  tca_pkg::out_item_t out_r;
  logic [AW-1:0]  clr_r;
  logic [LCW-1:0] lane_r;
  logic [PW-1:0]  pos_r;
  logic           pend_r, first_r;
  logic [PW-1:0]  pend_p_r, first_p_r;
  logic [SB-1:0]  pend_v_r;
  logic [SB:0]    rd_data_r;

  logic [LW-1:0]  len_eff;
  logic [LCW-1:0] lanes_eff;
  logic [SB-1:0]  vmax_eff;
  logic           item_ok;
  logic [AW-1:0]  item_addr, lane_base, pos_addr, pend_addr, np_addr;
  logic           car;
  logic [SB-1:0]  car_v;
  logic           fin;
  logic [PW-1:0]  gap_cells;
  logic [LW:0]    wrap_sum, np_sum;
  logic [PW-1:0]  np;
  logic [SB-1:0]  v_acc, v_gap, v_clamp, v_fin;
  logic [15:0]    draw;
  logic           we, re;
  logic [AW-1:0]  wa, ra;
  logic [SB:0]    wd;

  // Effective settings after saturation.
  always_comb begin
    if (32'(len_cfg_r) > 32'(ROAD_CELLS)) len_eff = LW'(ROAD_CELLS);
    else if (len_cfg_r < 9'd2) len_eff = LW'(2);
    else len_eff = LW'(len_cfg_r);
    if (32'(lanes_cfg_r) > 32'(LANES)) lanes_eff = LCW'(LANES);
    else lanes_eff = LCW'(lanes_cfg_r);
    if (32'(vmax_cfg_r) > 32'(VMASK)) vmax_eff = SB'(VMASK);
    else vmax_eff = SB'(vmax_cfg_r);
  end

  assign item_ok   = (32'(item_r.lane) < 32'(LANES)) && (32'(item_r.cell_req) < 32'(ROAD_CELLS));
  assign item_addr = AW'(32'(item_r.lane) * ROAD_CELLS + 32'(item_r.cell_req));
  assign lane_base = AW'(32'(lane_r) * ROAD_CELLS);
  assign pos_addr  = lane_base + AW'(pos_r);
  assign pend_addr = lane_base + AW'(pend_p_r);
  assign car       = rd_data_r[SB];
  assign car_v     = rd_data_r[SB-1:0];

  // Gap to the next car ahead: the next car found in the sweep, or the first car
  // of the lane when the last pending car wraps around.
  assign wrap_sum  = (LW+1)'(first_p_r) + (LW+1)'(len_eff) - (LW+1)'(pend_p_r) - (LW+1)'(1);
  assign gap_cells = cmd.vel_final ? PW'(wrap_sum) : (pos_r - pend_p_r - PW'(1));
  assign fin       = pend_r && (cmd.vel_final || (cmd.vel_eval && car));
  assign draw      = tca_pkg::lfsr_step(lfsr_r);

  // The new velocity is capped by the gap to the car ahead and by the maximum velocity.
  always_comb begin
    v_acc   = (pend_v_r < vmax_eff) ? pend_v_r + SB'(1) : pend_v_r;
    v_gap   = (32'(v_acc) > 32'(gap_cells)) ? SB'(gap_cells) : v_acc;
    v_clamp = (v_gap > vmax_eff) ? vmax_eff : v_gap;
    v_fin   = ((draw < prob_r) && (v_clamp != '0)) ? v_clamp - SB'(1) : v_clamp;
  end

  assign np_sum  = (LW+1)'(pos_r) + (LW+1)'(car_v);
  assign np      = (np_sum >= (LW+1)'(len_eff)) ? PW'(np_sum - (LW+1)'(len_eff)) : PW'(np_sum);
  assign np_addr = lane_base + AW'(np);

  always_comb begin
    we = 1'b0;
    wa = clr_r;
    wd = '0;
    if (cmd.clr_wr) begin
      we = 1'b1;
    end else if (cmd.cell_wr) begin
      we = item_ok;
      wa = item_addr;
      wd = item_r.occupied_in ? {1'b1, SB'(item_r.velocity_in)} : '0;
    end else if (fin) begin
      we = 1'b1;
      wa = pend_addr;
      wd = {1'b1, v_fin};
    end else if (cmd.mv_clr) begin
      we = 1'b1;
      wa = pos_addr;
    end else if (cmd.mv_put) begin
      we = 1'b1;
      wa = np_addr;
      wd = rd_data_r;
    end
    re = (cmd.cell_rd && item_ok) || cmd.vel_rd || cmd.mv_rd;
    ra = cmd.cell_rd ? item_addr : pos_addr;
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rd_data_r <= mem[ra];
  end

  always_comb begin
    lfsr_nxt = lfsr_r;
    if (cfg_we && cfg_addr == tca_pkg::CFG_SEED)
      lfsr_nxt = (cfg_wdata == '0) ? 16'd1 : cfg_wdata;
    else if (fin)
      lfsr_nxt = draw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vmax_cfg_r  <= tca_pkg::VMAX_RST;
      prob_r      <= tca_pkg::PROB_RST;
      len_cfg_r   <= tca_pkg::LEN_RST;
      lanes_cfg_r <= tca_pkg::LANES_RST;
      lfsr_r      <= tca_pkg::SEED_RST;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      first_r     <= 1'b0;
    end else begin
      lfsr_r <= lfsr_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          tca_pkg::CFG_VMAX:  vmax_cfg_r  <= cfg_wdata[3:0];
          tca_pkg::CFG_PROB:  prob_r      <= cfg_wdata;
          tca_pkg::CFG_LEN:   len_cfg_r   <= cfg_wdata[8:0];
          tca_pkg::CFG_LANES: lanes_cfg_r <= cfg_wdata[2:0];
          default: ;
        endcase
      end
      if (cmd.clr_wr) clr_r <= clr_r + AW'(1);
      if (cmd.vel_init) begin
        pend_r  <= 1'b0;
        first_r <= 1'b0;
      end else if (cmd.vel_eval && car) begin
        pend_r  <= 1'b1;
        first_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) item_r <= in_data;
    if (cmd.lane_init) lane_r <= '0;
    else if (cmd.lane_next) lane_r <= lane_r + LCW'(1);
    if (cmd.vel_init) pos_r <= '0;
    else if (cmd.vel_eval) pos_r <= pos_r + PW'(1);
    else if (cmd.mv_init) pos_r <= PW'(len_eff - LW'(1));
    else if (cmd.mv_dec) pos_r <= pos_r - PW'(1);
    if (cmd.vel_eval && car) begin
      pend_p_r <= pos_r;
      pend_v_r <= car_v;
      if (!first_r) first_p_r <= pos_r;
    end
    if (cmd.out_load) begin
      out_r.occupied_out <= (item_r.action == tca_pkg::ACT_READ) && item_ok && car;
      out_r.velocity_out <= ((item_r.action == tca_pkg::ACT_READ) && item_ok && car) ?
                            4'(car_v) : 4'd0;
      out_r.step_done    <= (item_r.action == tca_pkg::ACT_STEP);
    end
  end

  assign out_data     = out_r;
  assign st.clr_last  = (clr_r == AW'(DEPTH - 1));
  assign st.act       = item_r.action;
  assign st.lane_more = (lane_r < lanes_eff);
  assign st.p_last    = (32'(pos_r) == 32'(len_eff) - 1);
  assign st.car       = car;
  assign st.any_car   = first_r;
  assign st.mv_last   = (pos_r == first_p_r);

endmodule

### hw/rtl/traffic_ca_velocity_and_move_step_unit.sv
// Channel  | Valid      | Stall      | Payload
// input    | in_valid   | in_stall   | in_data   (tca_pkg::in_item_t)
// result   | out_valid  | out_stall  | out_data  (tca_pkg::out_item_t)
// config   | cfg_we     | none       | cfg_addr, cfg_wdata
//
// After reset a clearing pass writes every one of LANES*ROAD_CELLS cells empty,
// one per cycle, while in_stall stays high. A step runs, per active lane, a velocity
// sweep over the road and then, if the lane holds a car, a move sweep from the road
// end down to the first car that reads each cell and clears and rewrites each car;
// the single-port writes of the cell memory set this split.
// A new transaction is taken while the previous result waits on out_stall.
// Top level; depends on tca_pkg, tca_ctrl and tca_datapath.
module traffic_ca_velocity_and_move_step_unit #(
  parameter int ROAD_CELLS = tca_pkg::ROAD_CELLS_DEF,
  parameter int LANES      = tca_pkg::LANES_DEF,
  parameter int SPEED_BITS = tca_pkg::SPEED_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  tca_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output tca_pkg::out_item_t         out_data,
  input  logic                       cfg_we,
  input  logic [tca_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [tca_pkg::CFG_DW-1:0] cfg_wdata
);

  tca_pkg::cmd_t    cmd;
  tca_pkg::status_t st;

  tca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  tca_datapath #(
    .ROAD_CELLS (ROAD_CELLS),
    .LANES      (LANES),
    .SPEED_BITS (SPEED_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .st        (st),
    .out_data  (out_data)
  );

endmodule

### hw/rtl/tca_checker.sv
// Port-level checks for the traffic automaton step unit, bound to the top level.
// Depends on tca_pkg and traffic_ca_velocity_and_move_step_unit.
module tca_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input tca_pkg::out_item_t out_data
);

  // No result is pending right after reset.
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A result held by the receiver keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // An accepted transaction keeps the input closed while it is worked on.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input open during a transaction");

  // A step report never carries cell contents.
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.step_done |-> !out_data.occupied_out && out_data.velocity_out == 4'd0)
    else $error("step result mixed with read data");

endmodule

bind traffic_ca_velocity_and_move_step_unit tca_checker u_tca_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### dv/tb.sv
// Testbench for the traffic cellular automaton step unit: cell writes, reads and
// time steps checked against a scoreboard that models the store, the LFSR and registers.
// Depends on tca_pkg and traffic_ca_velocity_and_move_step_unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCELLS = 256;
  localparam int NLANES = 4;
  localparam int STORE = NCELLS * NLANES;
  localparam longint CYCLE_LIMIT = 64'd8_000_000;

  class road_scoreboard;
    logic [4:0]         cells [STORE];
    logic [3:0]         vmax_reg;
    logic [15:0]        prob_reg;
    logic [8:0]         len_reg;
    logic [2:0]         lanes_reg;
    logic [15:0]        lfsr;
    tca_pkg::out_item_t pending [$];
    int                 errors;
    int                 checked;

    function void init();
      foreach (cells[i]) cells[i] = '0;
      vmax_reg = tca_pkg::VMAX_RST;
      prob_reg = tca_pkg::PROB_RST;
      len_reg = tca_pkg::LEN_RST;
      lanes_reg = tca_pkg::LANES_RST;
      lfsr = tca_pkg::SEED_RST;
      pending.delete();
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        tca_pkg::CFG_VMAX:  vmax_reg = val[3:0];
        tca_pkg::CFG_PROB:  prob_reg = val;
        tca_pkg::CFG_LEN:   len_reg = val[8:0];
        tca_pkg::CFG_LANES: lanes_reg = val[2:0];
        tca_pkg::CFG_SEED:  lfsr = (val == 16'd0) ? 16'd1 : val;
        default: ;
      endcase
    endfunction

    function void advance_road();
      int len, nl, vm, reach, gap, v, np, base;
      logic [4:0] nxt [STORE];
      len = len_reg;
      if (len > NCELLS) len = NCELLS;
      if (len < 2) len = 2;
      nl = lanes_reg > NLANES ? NLANES : lanes_reg;
      vm = vmax_reg;
      reach = vm < len - 1 ? vm : len - 1;
      for (int ln = 0; ln < nl; ln++) begin
        base = ln * NCELLS;
        for (int p = 0; p < len; p++) begin
          if (!cells[base + p][4]) continue;
          v = cells[base + p][3:0];
          if (v < vm) v++;
          gap = 0;
          for (int k = 1; k <= reach; k++) begin
            if (cells[base + (p + k) % len][4]) break;
            gap++;
          end
          if (v > gap) v = gap;
          lfsr = (lfsr >> 1) ^ (lfsr[0] ? tca_pkg::LFSR_TAPS : 16'h0);
          if (lfsr < prob_reg && v > 0) v--;
          cells[base + p] = {1'b1, 4'(v)};
        end
      end
      nxt = cells;
      for (int ln = 0; ln < nl; ln++) begin
        base = ln * NCELLS;
        for (int p = 0; p < len; p++) begin
          if (!cells[base + p][4]) continue;
          np = (p + cells[base + p][3:0]) % len;
          nxt[base + p] = '0;
          nxt[base + np] = cells[base + p];
        end
      end
      cells = nxt;
    endfunction

    function void note_input(tca_pkg::in_item_t it);
      tca_pkg::out_item_t r;
      int idx;
      r = '0;
      idx = it.lane * NCELLS + it.cell_req;
      case (it.action)
        tca_pkg::ACT_WRITE: cells[idx] = it.occupied_in ? {1'b1, it.velocity_in} : 5'd0;
        tca_pkg::ACT_READ:  if (cells[idx][4]) begin
          r.occupied_out = 1'b1;
          r.velocity_out = cells[idx][3:0];
        end
        tca_pkg::ACT_STEP: begin
          advance_road();
          r.step_done = 1'b1;
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    task report_error(string what, int got, int want);
      errors++;
      $display("ERROR result %0d: %s got %0d expected %0d", checked, what, got, want);
    endtask

    task check_result(tca_pkg::out_item_t got);
      tca_pkg::out_item_t exp_r;
      checked++;
      if (pending.size() == 0) begin
        report_error("result with nothing outstanding", 0, 0);
        return;
      end
      exp_r = pending.pop_front();
      if (got.occupied_out !== exp_r.occupied_out)
        report_error("occupied_out", got.occupied_out, exp_r.occupied_out);
      if (got.velocity_out !== exp_r.velocity_out)
        report_error("velocity_out", got.velocity_out, exp_r.velocity_out);
      if (got.step_done !== exp_r.step_done)
        report_error("step_done", got.step_done, exp_r.step_done);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  tca_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tca_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [tca_pkg::CFG_AW-1:0] cfg_addr = '0;
  logic [tca_pkg::CFG_DW-1:0] cfg_wdata = '0;
  longint cycles = 0;
  int n_steps = 0;
  road_scoreboard sb;

  always #1 clk = ~clk;

  traffic_ca_velocity_and_move_step_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // Result monitor, plus the receiver's stall pattern: busy runs and quiet runs.
  int stall_mode = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("traffic_ca_velocity_and_move_step_unit: mismatch");
      $finish;
    end
  end

  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 1) == 0);
    endcase
  end

  // Valid stays high across a burst; it drops only for a gap or a drain.
  task automatic send_item(tca_pkg::in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(it);
    if (it.action == tca_pkg::ACT_STEP) n_steps++;
    @(negedge clk);
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic tca_pkg::in_item_t mk(logic [1:0] a, int ln, int c, bit o, int v);
    tca_pkg::in_item_t it;
    it.action = a;
    it.lane = ln[1:0];
    it.cell_req = c[7:0];
    it.occupied_in = o;
    it.velocity_in = v[3:0];
    return it;
  endfunction

  // Random phase: populate a few cars in the active area, step, read back, raw items.
  task automatic random_phase(int len, int nl, int n);
    tca_pkg::in_item_t it;
    int r;
    logic [31:0] rw;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45)
        it = mk(tca_pkg::ACT_WRITE, $urandom_range(0, nl - 1), $urandom_range(0, len - 1),
                $urandom_range(0, 3) != 0, $urandom_range(0, 15));
      else if (r < 75)
        it = mk(tca_pkg::ACT_READ, $urandom_range(0, nl - 1), $urandom_range(0, len - 1),
                0, 0);
      else if (r < 93)
        it = mk(tca_pkg::ACT_STEP, 0, 0, 0, 0);
      else begin
        rw = $urandom();
        it = tca_pkg::in_item_t'(rw[16:0]);
      end
      send_item(it);
    end
  endtask

  initial begin
    sb = new();
    sb.init();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, empty writes, wide velocity, unused action, steps.
    send_item(mk(tca_pkg::ACT_WRITE, 0, 0, 1, 15));
    send_item(mk(tca_pkg::ACT_WRITE, 3, 255, 1, 15));
    send_item(mk(tca_pkg::ACT_WRITE, 2, 128, 0, 9));
    send_item(mk(tca_pkg::ACT_READ, 0, 0, 0, 0));
    send_item(mk(tca_pkg::ACT_READ, 3, 255, 0, 0));
    send_item(mk(tca_pkg::ACT_READ, 2, 128, 0, 0));
    send_item(mk(tca_pkg::ACT_READ, 1, 77, 1, 15));
    send_item(mk(tca_pkg::ACT_WRITE, 0, 1, 1, 0));
    send_item(mk(tca_pkg::ACT_WRITE, 0, 255, 1, 3));
    send_item(mk(2'd3, 3, 255, 1, 15));
    send_item(mk(tca_pkg::ACT_STEP, 0, 0, 0, 0));
    for (int c = 0; c < 8; c++) send_item(mk(tca_pkg::ACT_READ, 0, c, 0, 0));
    send_item(mk(tca_pkg::ACT_READ, 0, 255, 0, 0));
    send_item(mk(tca_pkg::ACT_STEP, 3, 200, 1, 7));
    send_item(mk(tca_pkg::ACT_READ, 3, 255, 0, 0));
    drain();

    // Short ring, all lanes, top speed, slow down on nearly every draw.
    write_reg(tca_pkg::CFG_VMAX, 16'd15);
    write_reg(tca_pkg::CFG_PROB, 16'hFFFF);
    write_reg(tca_pkg::CFG_LEN, 16'd2);
    write_reg(tca_pkg::CFG_LANES, 16'd4);
    write_reg(tca_pkg::CFG_SEED, 16'd1);
    random_phase(2, 4, 40);
    drain();

    // Speed limit one, never slow down, odd length, out-of-range values saturated.
    write_reg(tca_pkg::CFG_VMAX, 16'd1);
    write_reg(tca_pkg::CFG_PROB, 16'd0);
    write_reg(tca_pkg::CFG_LEN, 16'd37);
    write_reg(tca_pkg::CFG_LANES, 16'd7);
    write_reg(tca_pkg::CFG_SEED, 16'hFFFF);
    random_phase(37, 4, 60);
    drain();

    write_reg(tca_pkg::CFG_LANES, 16'd0);
    write_reg(tca_pkg::CFG_LEN, 16'd0);
    write_reg(tca_pkg::CFG_SEED, 16'd0);
    random_phase(2, 4, 20);
    drain();

    write_reg(tca_pkg::CFG_VMAX, 16'd0);
    write_reg(tca_pkg::CFG_LANES, 16'd2);
    write_reg(tca_pkg::CFG_LEN, 16'd511);
    random_phase(256, 2, 20);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      int len, nl;
      len = $urandom_range(2, 48);
      nl = $urandom_range(1, 4);
      write_reg(tca_pkg::CFG_VMAX, 16'($urandom_range(1, 15)));
      write_reg(tca_pkg::CFG_PROB, 16'($urandom()));
      write_reg(tca_pkg::CFG_LEN, 16'(len));
      write_reg(tca_pkg::CFG_LANES, 16'(nl));
      write_reg(tca_pkg::CFG_SEED, 16'($urandom_range(1, 65535)));
      random_phase(len, nl, 26);
      drain();
    end

    $display("covered %0d results including %0d road steps over several register settings",
             sb.checked, n_steps);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("traffic_ca_velocity_and_move_step_unit: match");
    else
      $display("traffic_ca_velocity_and_move_step_unit: mismatch");
    $finish;
  end
endmodule
